@@ hdl/dks_pkg.sv @@
// package for the draw order key sorter
// holds the entry record, the cell control group and the ordering function
// used by dks_cell and draw_order_key_sorter
package dks_pkg;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] seq;
		logic [15:0] handle;
	} entry_t;

	typedef struct packed {
		logic load;
		logic pop;
	} cell_ctrl_t;

	// strict order: signed key, then unsigned sequence
	function automatic logic goes_before(input entry_t a, input entry_t b);
		logic key_lt;
		logic key_eq;
		logic seq_lt;
		key_lt = $signed(a.key) < $signed(b.key);
		key_eq = a.key == b.key;
		seq_lt = a.seq < b.seq;
		return key_lt || (key_eq && seq_lt);
	endfunction

endpackage

@@ hdl/dks_cell.sv @@
// one cell of the sorted register chain: holds one entry and its valid bit
// inserts from the broadcast input or the left neighbor, pops from the right neighbor
// depends on dks_pkg
module dks_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dks_pkg::cell_ctrl_t ctrl,
	input  dks_pkg::entry_t     new_entry,
	input  logic                prev_take,
	input  logic                prev_valid,
	input  dks_pkg::entry_t     prev_entry,
	input  logic                next_valid,
	input  dks_pkg::entry_t     next_entry,
	output logic                take,
	output logic                valid,
	output dks_pkg::entry_t     entry
);

	logic            valid_q;
	dks_pkg::entry_t entry_q;

	assign take  = !valid_q || dks_pkg::goes_before(new_entry, entry_q);
	assign valid = valid_q;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (ctrl.load && take) begin
			valid_q <= valid_q || !prev_take || prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			entry_q <= next_entry;
		end else if (ctrl.load && take) begin
			entry_q <= prev_take ? prev_entry : new_entry;
		end
	end

endmodule

@@ hdl/draw_order_key_sorter.sv @@
// draw order key sorter: stable insertion sort over a chain of register cells
// top level; depends on dks_pkg and dks_cell
//
// input channel (in_valid/in_ready) takes one entry per cycle while loading;
// each transaction inserts the entry into its sorted place in the cell chain
// in the same cycle. order is signed key, then unsigned sequence, then arrival.
// at most MAX_ENTRIES entries are held; later ones are dropped and every result
// of that list carries overflow. the transaction with last_entry set ends the list.
// after that, in_ready drops and the chain drains from its head: once the state
// register has moved to drain, the first result is popped into the output
// register, then one result per cycle while out_ready stays high. a stalled
// receiver holds the output register and freezes the chain. run_end marks the
// final result. in_ready returns in the same cycle as the final result appears
// in the output register. results leave only through the single pop port at
// the chain head.
// reset (arst_n low) empties the chain and clears count, overflow and output.
module draw_order_key_sorter #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] depth_key,
	input  logic        [31:0] insert_seq,
	input  logic        [15:0] entry_handle,
	input  logic               last_entry,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] sorted_handle,
	output logic signed [31:0] sorted_key,
	output logic        [31:0] sorted_seq,
	output logic               run_end,
	output logic               overflow
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic                dropped_q;
	logic                out_valid_q;
	dks_pkg::entry_t     out_entry_q;
	logic                run_end_q;
	logic                overflow_q;

	logic                accept;
	logic                full;
	logic                pop;
	dks_pkg::cell_ctrl_t ctrl;
	dks_pkg::entry_t     new_entry;

	logic [MAX_ENTRIES-1:0] take_w;
	logic [MAX_ENTRIES-1:0] valid_w;
	dks_pkg::entry_t        entry_w [MAX_ENTRIES];

	assign in_ready  = state_q == ST_LOAD;
	assign accept    = in_valid && in_ready;
	assign full      = count_q == CW'(MAX_ENTRIES);
	assign pop       = state_q == ST_DRAIN && count_q != '0 && (!out_valid_q || out_ready);
	assign ctrl.load = accept && !full;
	assign ctrl.pop  = pop;

	assign new_entry.key    = depth_key;
	assign new_entry.seq    = insert_seq;
	assign new_entry.handle = entry_handle;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic            prev_take;
		logic            prev_valid;
		dks_pkg::entry_t prev_entry;
		logic            next_valid;
		dks_pkg::entry_t next_entry;

		if (i == 0) begin : g_head
			assign prev_take  = 1'b0;
			assign prev_valid = 1'b0;
			assign prev_entry = new_entry;
		end else begin : g_body
			assign prev_take  = take_w[i-1];
			assign prev_valid = valid_w[i-1];
			assign prev_entry = entry_w[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_entry = new_entry;
		end else begin : g_mid
			assign next_valid = valid_w[i+1];
			assign next_entry = entry_w[i+1];
		end

		dks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.prev_take  (prev_take),
			.prev_valid (prev_valid),
			.prev_entry (prev_entry),
			.next_valid (next_valid),
			.next_entry (next_entry),
			.take       (take_w[i]),
			.valid      (valid_w[i]),
			.entry      (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_entry_q <= '0;
			run_end_q   <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (last_entry) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (pop) begin
						out_valid_q <= 1'b1;
						out_entry_q <= entry_w[0];
						run_end_q   <= count_q == CW'(1);
						overflow_q  <= dropped_q;
						count_q     <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							state_q   <= ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign sorted_handle = out_entry_q.handle;
	assign sorted_key    = $signed(out_entry_q.key);
	assign sorted_seq    = out_entry_q.seq;
	assign run_end       = run_end_q;
	assign overflow      = overflow_q;

`ifndef SYNTHESIS
	// occupied cells always form a prefix of the chain
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_w} + {{MAX_ENTRIES{1'b0}}, 1'b1}))
		else $error("occupied cells are not a prefix of the chain");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("entry count disagrees with occupied cells");

	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_entry |=> !in_ready && count_q != '0)
		else $error("list end did not start the drain");

	a_run_end_empties: assert property (@(posedge clk) disable iff (!arst_n)
		pop && count_q == CW'(1) |=> valid_w == '0 && !dropped_q)
		else $error("chain not empty after the final result");
`endif

endmodule

@@ test/dks_checker.sv @@
// passive checker for draw_order_key_sorter: watches both channels,
// predicts the sorted output of each list and compares every result transaction
// depends only on the port list of draw_order_key_sorter
module dks_checker #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] depth_key,
	input  logic        [31:0] insert_seq,
	input  logic        [15:0] entry_handle,
	input  logic               last_entry,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic        [15:0] sorted_handle,
	input  logic signed [31:0] sorted_key,
	input  logic        [31:0] sorted_seq,
	input  logic               run_end,
	input  logic               overflow,
	output int                 mismatches,
	output int                 results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        [15:0] handle;
		logic signed [31:0] key;
		logic        [31:0] seq;
		logic               last;
		logic               dropped;
	} sorted_rec_t;

	logic signed [31:0] held_key    [MAX_ENTRIES];
	logic        [31:0] held_seq    [MAX_ENTRIES];
	logic        [15:0] held_handle [MAX_ENTRIES];
	int                 held_count;
	logic               list_dropped;
	sorted_rec_t        sorted_q[$];
	int                 mismatch_cnt = 0;
	int                 due_cnt = 0;

	assign mismatches  = mismatch_cnt;
	assign results_due = due_cnt;

	function automatic bit sorts_ahead(input logic signed [31:0] ka, input logic [31:0] sa,
			input logic signed [31:0] kb, input logic [31:0] sb);
		return (ka < kb) || ((ka == kb) && (sa < sb));
	endfunction

	// stable insertion sort of the held list into expected results
	task automatic release_list();
		int order [MAX_ENTRIES];
		int pos;
		sorted_rec_t rec;
		for (int i = 0; i < held_count; i++) begin
			pos = i;
			while (pos > 0 && sorts_ahead(held_key[i], held_seq[i],
					held_key[order[pos-1]], held_seq[order[pos-1]])) begin
				order[pos] = order[pos-1];
				pos--;
			end
			order[pos] = i;
		end
		for (int i = 0; i < held_count; i++) begin
			rec.handle  = held_handle[order[i]];
			rec.key     = held_key[order[i]];
			rec.seq     = held_seq[order[i]];
			rec.last    = (i == held_count - 1);
			rec.dropped = list_dropped;
			sorted_q.push_back(rec);
		end
		held_count   = 0;
		list_dropped = 1'b0;
	endtask

	task automatic flag_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_rec_t exp_rec;
		if (!arst_n) begin
			sorted_q.delete();
			held_count   = 0;
			list_dropped = 1'b0;
			due_cnt      = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (sorted_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result transaction handle %h key %h seq %h",
						sorted_handle, sorted_key, sorted_seq));
				end else begin
					exp_rec = sorted_q.pop_front();
					if (sorted_handle !== exp_rec.handle || sorted_key !== exp_rec.key ||
							sorted_seq !== exp_rec.seq || run_end !== exp_rec.last ||
							overflow !== exp_rec.dropped) begin
						flag_mismatch($sformatf({"mismatch: expected handle %h key %h seq %h ",
							"end %b ovf %b, got handle %h key %h seq %h end %b ovf %b"},
							exp_rec.handle, exp_rec.key, exp_rec.seq, exp_rec.last,
							exp_rec.dropped, sorted_handle, sorted_key, sorted_seq,
							run_end, overflow));
					end
				end
			end
			if (in_valid && in_ready) begin
				if (held_count < MAX_ENTRIES) begin
					held_key[held_count]    = depth_key;
					held_seq[held_count]    = insert_seq;
					held_handle[held_count] = entry_handle;
					held_count++;
				end else begin
					list_dropped = 1'b1;
				end
				if (last_entry) begin
					release_list();
				end
			end
			due_cnt = sorted_q.size();
		end
	end

endmodule

@@ test/tb_draw_order_key_sorter.sv @@
// testbench top for draw_order_key_sorter: drives lists of entries with bursty
// input and a stalling receiver, and gives the verdict from dks_checker
// depends on draw_order_key_sorter and dks_checker
module tb_draw_order_key_sorter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ENTRIES    = 32;
	localparam int ITEM_TARGET    = 210;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_WAIT     = 40;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] depth_key;
	logic        [31:0] insert_seq;
	logic        [15:0] entry_handle;
	logic               last_entry;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic        [15:0] sorted_handle;
	logic signed [31:0] sorted_key;
	logic        [31:0] sorted_seq;
	logic               run_end;
	logic               overflow;
	int                 mismatches;
	int                 results_due;
	int                 items_sent;
	int                 burst_left;
	int                 idle_cycles = 0;
	int                 stall_mode = 0;
	int                 mode_left = 0;
	int                 hold_cnt = 0;

	draw_order_key_sorter #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.depth_key(depth_key),
		.insert_seq(insert_seq),
		.entry_handle(entry_handle),
		.last_entry(last_entry),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sorted_handle(sorted_handle),
		.sorted_key(sorted_key),
		.sorted_seq(sorted_seq),
		.run_end(run_end),
		.overflow(overflow)
	);

	dks_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.depth_key(depth_key),
		.insert_seq(insert_seq),
		.entry_handle(entry_handle),
		.last_entry(last_entry),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sorted_handle(sorted_handle),
		.sorted_key(sorted_key),
		.sorted_seq(sorted_seq),
		.run_end(run_end),
		.overflow(overflow),
		.mismatches(mismatches),
		.results_due(results_due)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver stall pattern: always ready, random, alternating, long stalls
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(10, 60);
		end
		mode_left--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ~out_ready;
			default: begin
				if (hold_cnt > 0) begin
					out_ready <= 1'b0;
					hold_cnt--;
				end else begin
					out_ready <= 1'b1;
					hold_cnt = $urandom_range(1, 12);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_draw_order_key_sorter failed");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_key();
		logic [31:0] extremes [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
		case ($urandom_range(0, 3))
			0: return extremes[$urandom_range(0, 3)];
			1: return 32'($signed($urandom_range(0, 6)) - 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_seq();
		logic [31:0] extremes [4] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
		case ($urandom_range(0, 3))
			0: return extremes[$urandom_range(0, 3)];
			1: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// called and returns at falling edges, after the transaction and any idle gap
	task automatic push_entry(input logic [31:0] k, input logic [31:0] s, input logic [15:0] h,
			input logic l);
		int gap;
		in_valid     <= 1'b1;
		depth_key    <= k;
		insert_seq   <= s;
		entry_handle <= h;
		last_entry   <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (results_due != 0);
	endtask

	initial begin
		int list_no;
		int len;
		int sel;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		depth_key    = '0;
		insert_seq   = '0;
		entry_handle = '0;
		last_entry   = 1'b0;
		items_sent   = 0;
		burst_left   = 4;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single entry list at the field extremes
		push_entry(32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		// mixed signs, key ties broken by sequence, full ties kept in arrival order
		push_entry(32'h7FFF_FFFF, 32'h0,         16'h0000, 1'b0);
		push_entry(32'h0,         32'd5,         16'h0001, 1'b0);
		push_entry(32'h0,         32'd3,         16'h0002, 1'b0);
		push_entry(32'h0,         32'd5,         16'h0003, 1'b0);
		push_entry(32'hFFFF_FFFF, 32'h0,         16'h0004, 1'b0);
		push_entry(32'h1,         32'hFFFF_FFFF, 16'h0005, 1'b0);
		push_entry(32'h8000_0000, 32'h0,         16'h0006, 1'b0);
		push_entry(32'h0001_0000, 32'd7,         16'h0007, 1'b1);
		// identical keys and sequences
		for (int i = 0; i < 6; i++) begin
			push_entry(32'hFFFF_0000, 32'd9, 16'(16'h00A0 + i), (i == 5));
		end
		// sequence compared unsigned
		push_entry(32'd5, 32'h8000_0000, 16'h1111, 1'b0);
		push_entry(32'd5, 32'h7FFF_FFFF, 16'h2222, 1'b0);
		push_entry(32'd5, 32'h0,         16'h3333, 1'b1);
		wait_for_drain();

		list_no = 0;
		while (items_sent < ITEM_TARGET) begin
			list_no++;
			case (list_no)
				2: len = MAX_ENTRIES;
				4: len = MAX_ENTRIES + 1;
				7: len = MAX_ENTRIES + 5;
				default: begin
					sel = $urandom_range(0, 19);
					if (sel < 17) len = $urandom_range(1, 10);
					else if (sel < 19) len = $urandom_range(11, MAX_ENTRIES - 1);
					else len = $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 8);
				end
			endcase
			for (int i = 0; i < len; i++) begin
				push_entry(pick_key(), pick_seq(), 16'($urandom_range(0, 65535)), (i == len - 1));
			end
			if ($urandom_range(0, 5) == 0) begin
				wait_for_drain();
			end
		end

		wait_for_drain();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && results_due == 0) begin
			$display("tb_draw_order_key_sorter passed");
		end else begin
			$display("tb_draw_order_key_sorter failed");
		end
		$finish;
	end

endmodule
